/* sv/bitplane_to_chunky_palette_unit_assert.svh */
// Assertion macros shared by the converter RTL.
`ifndef BITPLANE_TO_CHUNKY_PALETTE_UNIT_ASSERT_SVH
`define BITPLANE_TO_CHUNKY_PALETTE_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define B2C_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define B2C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter assertion failed");

`endif

/* sv/b2c_pkg.sv */
`default_nettype none

package b2c_pkg;

    localparam int PLANE_COUNT  = 8;
    localparam int PLANE_W      = 16;
    localparam int INDEX_W      = 8;
    localparam int RGB_W        = 24;
    localparam int GROUP_PIXELS = 16;
    localparam int POS_W        = $clog2(GROUP_PIXELS);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(GROUP_PIXELS - 1);

    typedef enum logic [0:0] {
        OP_CONVERT   = 1'b0,
        OP_PAL_WRITE = 1'b1
    } opcode_t;

    localparam logic [0:0] REG_PLANE_MODE  = 1'b0;
    localparam logic [0:0] REG_SAMPLE_HOLD = 1'b1;

    localparam logic [1:0] PLANES_1 = 2'd0;
    localparam logic [1:0] PLANES_2 = 2'd1;
    localparam logic [1:0] PLANES_4 = 2'd2;
    localparam logic [1:0] PLANES_8 = 2'd3;

    typedef struct packed {
        opcode_t              opcode;
        logic [PLANE_W-1:0]   plane0;
        logic [PLANE_W-1:0]   plane1;
        logic [PLANE_W-1:0]   plane2;
        logic [PLANE_W-1:0]   plane3;
        logic [PLANE_W-1:0]   plane4;
        logic [PLANE_W-1:0]   plane5;
        logic [PLANE_W-1:0]   plane6;
        logic [PLANE_W-1:0]   plane7;
        logic                 line_start;
        logic [INDEX_W-1:0]   pal_index;
        logic [RGB_W-1:0]     pal_rgb;
    } in_beat_t;

    typedef struct packed {
        logic [RGB_W-1:0]     pixel_rgb;
        logic [POS_W-1:0]     pixel_pos;
        logic                 last;
    } out_beat_t;

    typedef struct packed {
        logic                 rd_en;
        logic [INDEX_W-1:0]   index;
        logic [POS_W-1:0]     pos;
        logic                 last;
    } lookup_req_t;

    typedef struct packed {
        logic                 active;
        logic                 last_issue;
    } grp_status_t;

endpackage

`default_nettype wire

/* sv/b2c_group.sv */
`default_nettype none

module b2c_group
    import b2c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire in_beat_t    beat,
    input  wire logic [1:0]  plane_mode,
    input  wire logic        sample_hold_enable,
    input  wire logic        advance,
    output grp_status_t      status,
    output lookup_req_t      req
);

    logic [PLANE_W-1:0] words_reg [PLANE_COUNT];
    logic [PLANE_W-1:0] words_in  [PLANE_COUNT];
    logic               active_reg, active_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ls_reg;
    logic [INDEX_W-1:0] held_reg, held_next;
    logic [INDEX_W-1:0] held_cur;
    logic [INDEX_W-1:0] pix_index;
    logic [INDEX_W-1:0] look_index;
    logic [PLANE_COUNT-1:0] plane_keep;
    logic [POS_W-1:0]   bit_sel;

    always_comb
    begin
        case (plane_mode)
            PLANES_1: plane_keep = 8'h01;
            PLANES_2: plane_keep = 8'h03;
            PLANES_4: plane_keep = 8'h0F;
            PLANES_8: plane_keep = 8'hFF;
            default:  plane_keep = 8'hFF;
        endcase
    end

    assign words_in[0] = beat.plane0 & {PLANE_W{plane_keep[0]}};
    assign words_in[1] = beat.plane1 & {PLANE_W{plane_keep[1]}};
    assign words_in[2] = beat.plane2 & {PLANE_W{plane_keep[2]}};
    assign words_in[3] = beat.plane3 & {PLANE_W{plane_keep[3]}};
    assign words_in[4] = beat.plane4 & {PLANE_W{plane_keep[4]}};
    assign words_in[5] = beat.plane5 & {PLANE_W{plane_keep[5]}};
    assign words_in[6] = beat.plane6 & {PLANE_W{plane_keep[6]}};
    assign words_in[7] = beat.plane7 & {PLANE_W{plane_keep[7]}};

    // Leftmost pixel takes the top bit of each plane word.
    assign bit_sel = LAST_POS - pos_reg;

    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            pix_index[p] = words_reg[p][bit_sel];
        end
    end

    assign held_cur = (ls_reg && (pos_reg == '0)) ? '0 : held_reg;

    always_comb
    begin
        look_index = pix_index;
        held_next  = held_reg;
        if (sample_hold_enable && (pix_index == '0))
        begin
            look_index = held_cur;
        end
        if (advance)
        begin
            held_next = held_cur;
            if (sample_hold_enable && (pix_index != '0))
            begin
                held_next = pix_index;
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        if (start)
        begin
            active_next = 1'b1;
            pos_next    = '0;
        end
        else if (advance)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == LAST_POS)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            held_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            words_reg <= words_in;
            ls_reg    <= beat.line_start;
        end
    end

    assign status.active     = active_reg;
    assign status.last_issue = active_reg && (pos_reg == LAST_POS);

    assign req.rd_en = advance;
    assign req.index = look_index;
    assign req.pos   = pos_reg;
    assign req.last  = (pos_reg == LAST_POS);

endmodule

`default_nettype wire

/* sv/b2c_palette.sv */
`default_nettype none

module b2c_palette
    import b2c_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_index,
    input  wire logic [RGB_W-1:0]   wr_rgb,
    input  wire lookup_req_t        req,
    output logic [RGB_W-1:0]        rd_rgb
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [INDEX_W:0] ENTRIES_W = (INDEX_W + 1)'(PALETTE_ENTRIES);

    logic [RGB_W-1:0]           mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic [RGB_W-1:0]           rd_data_reg;
    logic                       hit_reg;
    logic                       wr_ok;
    logic                       rd_ok;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;

    assign wr_ok   = wr_en && ({1'b0, wr_index} < ENTRIES_W);
    assign rd_ok   = {1'b0, req.index} < ENTRIES_W;
    assign wr_addr = wr_index[AW-1:0];
    assign rd_addr = req.index[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= wr_rgb;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entries never written since reset read as black.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= rd_ok && valid_reg[rd_addr];
            end
        end
    end

    assign rd_rgb = hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* sv/bitplane_to_chunky_palette_unit.sv */
`default_nettype none

// Planar-to-chunky converter with a 24-bit RGB palette. A convert beat carries
// up to eight 16-bit plane words and produces sixteen pixel beats, leftmost
// first, one per cycle while the output is not stalled; a pixel counter walks
// the group through the single palette read port. The next beat is taken in
// the cycle that issues the sixteenth pixel, so groups stream without gaps.
// A palette-write beat produces no pixel. Pixels are registered at the palette
// read; the output register holds a pixel until it is taken, and the converter
// stalls while it waits.
// The palette reads as black after reset through per-entry valid bits, with
// no clearing pass. Write plane_mode and sample_hold_enable only while idle.
module bitplane_to_chunky_palette_unit
    import b2c_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_beat_t    in_beat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_beat_t        out_beat
);

    `include "bitplane_to_chunky_palette_unit_assert.svh"

    logic [1:0]       plane_mode_reg;
    logic             sample_hold_reg;
    logic             in_fire;
    logic             start;
    logic             pal_wr;
    logic             advance;
    grp_status_t      grp_status;
    lookup_req_t      req;
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] pos_reg;
    logic             last_reg;
    logic [RGB_W-1:0] rd_rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_mode_reg  <= PLANES_1;
            sample_hold_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PLANE_MODE:  plane_mode_reg  <= cfg_data;
                REG_SAMPLE_HOLD: sample_hold_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance  = grp_status.active && (!out_valid_reg || out_ready);
    assign in_ready = !grp_status.active || (advance && grp_status.last_issue);
    assign in_fire  = in_valid && in_ready;
    assign start    = in_fire && (in_beat.opcode == OP_CONVERT);
    assign pal_wr   = in_fire && (in_beat.opcode == OP_PAL_WRITE);

    b2c_group u_group (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .beat               (in_beat),
        .plane_mode         (plane_mode_reg),
        .sample_hold_enable (sample_hold_reg),
        .advance            (advance),
        .status             (grp_status),
        .req                (req)
    );

    b2c_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (pal_wr),
        .wr_index (in_beat.pal_index),
        .wr_rgb   (in_beat.pal_rgb),
        .req      (req),
        .rd_rgb   (rd_rgb)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_reg  <= req.pos;
            last_reg <= req.last;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_beat.pixel_rgb = rd_rgb;
    assign out_beat.pixel_pos = pos_reg;
    assign out_beat.last      = last_reg;

    `B2C_ASSERT_SAME(a_busy_blocks_input, grp_status.active && !grp_status.last_issue, !in_ready)
    `B2C_ASSERT_NEXT(a_start_loads_group, start, grp_status.active && (req.pos == '0))
    `B2C_ASSERT_NEXT(a_last_reaches_output, advance && req.last, out_valid && out_beat.last)
    `B2C_ASSERT_SAME(a_pos_matches_last, out_valid, out_beat.last == (out_beat.pixel_pos == LAST_POS))

endmodule

`default_nettype wire
